### src/tmcw_pkg.sv
`default_nettype none

package tmcw_pkg;

  // Default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Byte widths of the cell fields and the width of the command code
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CMD_W  = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUT_AT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd5;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE      = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
  localparam logic [ATTR_W+CHAR_W-1:0] BLANK_CELL = {BLANK_ATTR, SPACE};

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_ACCESS,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_PREP,
    OP_ACCESS,
    OP_COPY,
    OP_FILL,
    OP_EMIT
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic is_clear;
    logic scroll_need;
    logic fill_last;
    logic copy_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### src/tmcw_ctrl.sv
`default_nettype none

module tmcw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tmcw_pkg::dp_status_t sts,
  output tmcw_pkg::op_t             op
);

  tmcw_pkg::state_t state;
  tmcw_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tmcw_pkg::ST_INIT: begin
        if (sts.fill_last) state_next = tmcw_pkg::ST_IDLE;
      end
      tmcw_pkg::ST_IDLE: begin
        if (in_valid) state_next = tmcw_pkg::ST_PREP;
      end
      tmcw_pkg::ST_PREP: begin
        state_next = sts.is_clear ? tmcw_pkg::ST_CLEAR : tmcw_pkg::ST_ACCESS;
      end
      tmcw_pkg::ST_ACCESS: begin
        state_next = sts.scroll_need ? tmcw_pkg::ST_SCROLL : tmcw_pkg::ST_EMIT;
      end
      tmcw_pkg::ST_SCROLL: begin
        if (sts.copy_last) state_next = tmcw_pkg::ST_EMIT;
      end
      tmcw_pkg::ST_CLEAR: begin
        if (sts.fill_last) state_next = tmcw_pkg::ST_EMIT;
      end
      tmcw_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = tmcw_pkg::ST_IDLE;
      end
      default: state_next = tmcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op       = tmcw_pkg::OP_NONE;
    in_stall = 1'b1;
    case (state)
      tmcw_pkg::ST_INIT: op = tmcw_pkg::OP_FILL;
      tmcw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = tmcw_pkg::OP_LATCH;
      end
      tmcw_pkg::ST_PREP:   op = tmcw_pkg::OP_PREP;
      tmcw_pkg::ST_ACCESS: op = tmcw_pkg::OP_ACCESS;
      tmcw_pkg::ST_SCROLL: op = tmcw_pkg::OP_COPY;
      tmcw_pkg::ST_CLEAR:  op = tmcw_pkg::OP_FILL;
      tmcw_pkg::ST_EMIT: begin
        if (sts.out_free) op = tmcw_pkg::OP_EMIT;
      end
      default: op = tmcw_pkg::OP_NONE;
    endcase
  end

  // The power-up clearing pass runs once only
  assert property (@(posedge clk) disable iff (rst)
    (state != tmcw_pkg::ST_INIT) |=> (state != tmcw_pkg::ST_INIT))
    else $error("clearing pass re-entered");

  // Scroll follows only an access that called for one
  assert property (@(posedge clk) disable iff (rst)
    (state == tmcw_pkg::ST_ACCESS && !sts.scroll_need) |=> (state != tmcw_pkg::ST_SCROLL))
    else $error("scroll without cause");

  // The clear-state screen fill only serves a clear request
  assert property (@(posedge clk) disable iff (rst)
    (state == tmcw_pkg::ST_CLEAR) |-> sts.is_clear)
    else $error("fill without clear request");

endmodule

`default_nettype wire

### src/tmcw_datapath.sv
`default_nettype none

module tmcw_datapath #(
  parameter int COLS = tmcw_pkg::COLS_DEF,
  parameter int ROWS = tmcw_pkg::ROWS_DEF,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tmcw_pkg::op_t                 op,
  output tmcw_pkg::dp_status_t               sts,
  input  wire logic [tmcw_pkg::CMD_W-1:0]    cmd,
  input  wire logic [tmcw_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tmcw_pkg::ATTR_W-1:0]   attribute,
  input  wire logic [COL_W-1:0]              col,
  input  wire logic [ROW_W-1:0]              row,
  input  wire logic                          last_char,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [COL_W-1:0]                   cursor_col,
  output logic [ROW_W-1:0]                   cursor_row,
  output logic [tmcw_pkg::CHAR_W-1:0]        cell_char,
  output logic [tmcw_pkg::ATTR_W-1:0]        cell_attr,
  output logic                               scrolled,
  output logic                               string_done
);

  localparam int CELLS  = COLS * ROWS;
  localparam int SHIFT  = CELLS - COLS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int DATA_W = tmcw_pkg::ATTR_W + tmcw_pkg::CHAR_W;

  localparam logic [COL_W:0]    COLS_V  = (COL_W + 1)'(COLS);
  localparam logic [ROW_W:0]    ROWS_V  = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W-1:0]  COL_MAX = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(ROWS - 1);
  localparam logic [CELL_W-1:0] COLS_C  = CELL_W'(COLS);
  localparam logic [CNT_W-1:0]  SHIFT_K = CNT_W'(SHIFT);
  localparam logic [CNT_W-1:0]  COLS_K  = CNT_W'(COLS);
  localparam logic [CNT_W-1:0]  FILL_K  = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  COPY_K  = CNT_W'(CELLS);

  // Request registers
  logic [tmcw_pkg::CMD_W-1:0]  req_cmd;
  logic [tmcw_pkg::CHAR_W-1:0] req_char;
  logic [tmcw_pkg::ATTR_W-1:0] req_attr;
  logic [COL_W-1:0]            req_col;
  logic [ROW_W-1:0]            req_row;
  logic                        req_last;

  // Cursor, access and sweep state
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CELL_W-1:0] addr;
  logic              hit;
  logic              rd_hit;
  logic              scroll_pend;
  logic [CNT_W-1:0]  k;

  // Screen memory
  logic [DATA_W-1:0] mem [CELLS];
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [CELL_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CELL_W-1:0] rd_addr;

  // Decode helpers
  logic              is_nl;
  logic              in_range;
  logic              last_col;
  logic              last_row;
  logic              wrap_now;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  tgt_row;
  logic [CELL_W-1:0] addr_calc;

  assign is_nl    = (req_char == tmcw_pkg::NEWLINE);
  assign in_range = ({1'b0, req_col} < COLS_V) && ({1'b0, req_row} < ROWS_V);
  assign last_col = (cur_col == COL_MAX);
  assign last_row = (cur_row == ROW_MAX);
  assign wrap_now = (req_cmd == tmcw_pkg::CMD_PUT_CHAR) && !is_nl && last_col && last_row;
  assign sat_col  = ({1'b0, req_col} < COLS_V) ? req_col : COL_MAX;
  assign sat_row  = ({1'b0, req_row} < ROWS_V) ? req_row : ROW_MAX;

  // Step the cursor back one cell, holding at home
  always_comb begin
    bs_col = '0;
    bs_row = '0;
    if (cur_col != '0) begin
      bs_col = cur_col - COL_W'(1);
      bs_row = cur_row;
    end else if (cur_row != '0) begin
      bs_col = COL_MAX;
      bs_row = cur_row - ROW_W'(1);
    end
  end

  // Pick the cell that the request touches
  always_comb begin
    tgt_col = cur_col;
    tgt_row = cur_row;
    case (req_cmd)
      tmcw_pkg::CMD_BACKSPACE: begin
        tgt_col = bs_col;
        tgt_row = bs_row;
      end
      tmcw_pkg::CMD_PUT_AT, tmcw_pkg::CMD_READ_CELL: begin
        tgt_col = in_range ? req_col : '0;
        tgt_row = in_range ? req_row : '0;
      end
      default: begin
        tgt_col = cur_col;
        tgt_row = cur_row;
      end
    endcase
  end

  assign addr_calc = CELL_W'(tgt_row) * COLS_C + CELL_W'(tgt_col);

  // Memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = {req_attr, req_char};
    case (op)
      tmcw_pkg::OP_ACCESS: begin
        case (req_cmd)
          tmcw_pkg::CMD_PUT_CHAR: wr_en = !is_nl;
          tmcw_pkg::CMD_BACKSPACE: begin
            wr_en   = 1'b1;
            wr_data = {req_attr, tmcw_pkg::SPACE};
          end
          tmcw_pkg::CMD_PUT_AT: wr_en = hit;
          default: wr_en = 1'b0;
        endcase
      end
      tmcw_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_addr = k[CELL_W-1:0];
        wr_data = tmcw_pkg::BLANK_CELL;
      end
      tmcw_pkg::OP_COPY: begin
        // Write one row up what was read last cycle; blank the bottom row
        wr_en   = (k != '0);
        wr_addr = CELL_W'(k - CNT_W'(1));
        wr_data = (k <= SHIFT_K) ? rd_data : tmcw_pkg::BLANK_CELL;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Memory read port
  assign rd_addr = (op == tmcw_pkg::OP_COPY && k < SHIFT_K) ? CELL_W'(k + COLS_K) : addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (op == tmcw_pkg::OP_LATCH) begin
      req_cmd  <= cmd;
      req_char <= char_code;
      req_attr <= attribute;
      req_col  <= col;
      req_row  <= row;
      req_last <= last_char;
    end
  end

  // Hold the access address and range flag
  always_ff @(posedge clk) begin
    if (op == tmcw_pkg::OP_PREP) begin
      addr <= addr_calc;
      hit  <= in_range;
    end
  end

  // Cursor, scroll flag, read flag and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      scroll_pend <= 1'b0;
      rd_hit      <= 1'b0;
      k           <= '0;
    end else begin
      case (op)
        tmcw_pkg::OP_LATCH: begin
          scroll_pend <= 1'b0;
          rd_hit      <= 1'b0;
          k           <= '0;
        end
        tmcw_pkg::OP_PREP: begin
          case (req_cmd)
            tmcw_pkg::CMD_PUT_CHAR: begin
              if (is_nl) begin
                cur_col <= '0;
                if (last_row) scroll_pend <= 1'b1;
                else cur_row <= cur_row + ROW_W'(1);
              end
            end
            tmcw_pkg::CMD_BACKSPACE: begin
              cur_col <= bs_col;
              cur_row <= bs_row;
            end
            tmcw_pkg::CMD_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
            end
            tmcw_pkg::CMD_SET_CURSOR: begin
              cur_col <= sat_col;
              cur_row <= sat_row;
            end
            default: ;
          endcase
        end
        tmcw_pkg::OP_ACCESS: begin
          if (req_cmd == tmcw_pkg::CMD_PUT_CHAR && !is_nl) begin
            // Advance; past the last cell, park at the start of the last row
            if (last_col) begin
              cur_col <= '0;
              if (last_row) scroll_pend <= 1'b1;
              else cur_row <= cur_row + ROW_W'(1);
            end else begin
              cur_col <= cur_col + COL_W'(1);
            end
          end
          if (req_cmd == tmcw_pkg::CMD_READ_CELL) rd_hit <= hit;
        end
        tmcw_pkg::OP_FILL, tmcw_pkg::OP_COPY: k <= k + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == tmcw_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == tmcw_pkg::OP_EMIT) begin
      cursor_col  <= cur_col;
      cursor_row  <= cur_row;
      cell_char   <= rd_hit ? rd_data[tmcw_pkg::CHAR_W-1:0] : '0;
      cell_attr   <= rd_hit ? rd_data[DATA_W-1:tmcw_pkg::CHAR_W] : '0;
      scrolled    <= scroll_pend;
      string_done <= req_last;
    end
  end

  // Status to the controller
  assign sts.is_clear    = (req_cmd == tmcw_pkg::CMD_CLEAR);
  assign sts.scroll_need = scroll_pend || wrap_now;
  assign sts.fill_last   = (k == FILL_K);
  assign sts.copy_last   = (k == COPY_K);
  assign sts.out_free    = !out_valid || !out_stall;

  // Cursor stays on the screen
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < COLS_V) && ({1'b0, cur_row} < ROWS_V))
    else $error("cursor off screen");

  // Every write lands inside the screen
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} < (CELL_W + 1)'(CELLS)))
    else $error("write address out of range");

  // A new result is loaded only into a free output slot
  assert property (@(posedge clk) disable iff (rst)
    (op == tmcw_pkg::OP_EMIT) |-> (!out_valid || !out_stall))
    else $error("result overwritten");

endmodule

`default_nettype wire

### src/text_mode_console_writer.sv
`default_nettype none
// A request is taken in idle and passes the prep and access states; its result is
// registered in the emit state once the output is free, and only then is another
// request taken. A scrolling put_char adds a row copy through the one read port;
// a clear fills the screen instead of the access. Reset: synchronous; the cursor
// homes and a pass blanks the COLS*ROWS cells, one a cycle, stall high till done.

module text_mode_console_writer #(
  parameter int COLS = tmcw_pkg::COLS_DEF,
  parameter int ROWS = tmcw_pkg::ROWS_DEF,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tmcw_pkg::CMD_W-1:0]  cmd,
  input  wire logic [tmcw_pkg::CHAR_W-1:0] char_code,
  input  wire logic [tmcw_pkg::ATTR_W-1:0] attribute,
  input  wire logic [COL_W-1:0]            col,
  input  wire logic [ROW_W-1:0]            row,
  input  wire logic                        last_char,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [COL_W-1:0]                 cursor_col,
  output logic [ROW_W-1:0]                 cursor_row,
  output logic [tmcw_pkg::CHAR_W-1:0]      cell_char,
  output logic [tmcw_pkg::ATTR_W-1:0]      cell_attr,
  output logic                             scrolled,
  output logic                             string_done
);

  tmcw_pkg::op_t        op;
  tmcw_pkg::dp_status_t sts;

  // Sequencer
  tmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  // Screen memory, cursor and result register
  tmcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .sts         (sts),
    .cmd         (cmd),
    .char_code   (char_code),
    .attribute   (attribute),
    .col         (col),
    .row         (row),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .cell_char   (cell_char),
    .cell_attr   (cell_attr),
    .scrolled    (scrolled),
    .string_done (string_done)
  );

endmodule

`default_nettype wire
